### sv/md5_pkg.sv
// Package with the item types, constants and lookup functions of the MD5 engine.
`default_nettype none
package md5_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned BufDepth = 16;
  localparam int unsigned IdxW = 4;
  localparam int unsigned StepW = 6;
  localparam int unsigned TotalW = 64;

  localparam logic [WordW-1:0] InitA = 32'h67452301;
  localparam logic [WordW-1:0] InitB = 32'hefcdab89;
  localparam logic [WordW-1:0] InitC = 32'h98badcfe;
  localparam logic [WordW-1:0] InitD = 32'h10325476;
  localparam logic [7:0] PadMark = 8'h80;

  typedef struct packed {
    logic [31:0] message_word;
    logic [2:0]  byte_count;
    logic        last;
  } md5_in_t;

  typedef struct packed {
    logic [63:0] digest_hi;
    logic [63:0] digest_lo;
  } md5_out_t;

  typedef struct packed {
    logic [1:0] round;
    logic [4:0] shamt;
  } md5_step_ctrl_t;

  function automatic logic [WordW-1:0] md5_k(input logic [StepW-1:0] i);
    logic [WordW-1:0] k;
    case (i)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      6'd63: k = 32'heb86d391;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic logic [IdxW-1:0] md5_g(input logic [StepW-1:0] i);
    logic [IdxW-1:0] lo;
    logic [IdxW-1:0] g;
    lo = i[IdxW-1:0];
    case (i[5:4])
      2'd0: g = lo;
      2'd1: g = IdxW'((lo << 2) + lo + 4'd1);
      2'd2: g = IdxW'((lo << 1) + lo + 4'd5);
      2'd3: g = IdxW'((lo << 3) - lo);
      default: g = lo;
    endcase
    return g;
  endfunction

  function automatic logic [4:0] md5_rot(input logic [StepW-1:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
      default: s = 5'd7;
    endcase
    return s;
  endfunction

  function automatic logic [WordW-1:0] md5_bswap(input logic [WordW-1:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage
`default_nettype wire

### sv/md5_buffer.sv
// Generic RAM with one write port and one registered read port, used as the block buffer.
`default_nettype none
module md5_buffer #(
  parameter int unsigned Width = md5_pkg::WordW,
  parameter int unsigned Depth = md5_pkg::BufDepth
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [$clog2(Depth)-1:0]   wr_idx_i,
  input  wire logic [Width-1:0]           wr_data_i,
  input  wire logic [$clog2(Depth)-1:0]   rd_idx_i,
  output logic      [Width-1:0]           rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_idx_i];
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

### sv/md5_step.sv
// One MD5 step: round function, add of the prepared constant and word, rotate and add.
`default_nettype none
module md5_step (
  input  wire logic [md5_pkg::WordW-1:0] a_i,
  input  wire logic [md5_pkg::WordW-1:0] b_i,
  input  wire logic [md5_pkg::WordW-1:0] c_i,
  input  wire logic [md5_pkg::WordW-1:0] d_i,
  input  wire logic [md5_pkg::WordW-1:0] kw_i,
  input  wire md5_pkg::md5_step_ctrl_t   ctrl_i,
  output logic      [md5_pkg::WordW-1:0] b_o
);
  import md5_pkg::*;

  logic [WordW-1:0]   f;
  logic [WordW-1:0]   sum;
  logic [2*WordW-1:0] dbl;

  always_comb begin
    case (ctrl_i.round)
      2'd0: f = (b_i & c_i) | (~b_i & d_i);
      2'd1: f = (d_i & b_i) | (~d_i & c_i);
      2'd2: f = b_i ^ c_i ^ d_i;
      2'd3: f = c_i ^ (b_i | ~d_i);
      default: f = '0;
    endcase
  end

  assign sum = a_i + f + kw_i;
  assign dbl = {sum, sum} << ctrl_i.shamt;
  assign b_o = b_i + dbl[2*WordW-1:WordW];

endmodule
`default_nettype wire

### sv/md5_hash_engine.sv
// MD5 engine top level: word packing, padding sequencer and iterative compression.
//
// Message words enter on the in channel (valid/ready); each item carries zero to four
// bytes, first byte in bits 7..0. An item with last set or fewer than four bytes ends
// the message. The digest leaves on the out channel as one item per message.
// An item that neither fills a block nor ends the message leaves the block ready for
// the next item. A full block then runs one load state, 64 steps of the single shared
// step unit, and one add state that folds the result into the chaining words. At the
// end of a message the padding words are written one per cycle (up to 16), followed by
// one or two compressions and a final state that loads the digest into the output
// register.
// The block takes no item while it pads, compresses or holds a digest back. The output
// register holds the digest until the receiver takes it; the next message may stream
// in meanwhile, and its digest waits in the sequencer until the register is free.
// Reset returns the chaining words to their initial values and clears the counts.
`default_nettype none
module md5_hash_engine (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire md5_pkg::md5_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output md5_pkg::md5_out_t      out_data_o
);
  import md5_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPad  = 3'd1;
  localparam logic [2:0] StLoad = 3'd2;
  localparam logic [2:0] StStep = 3'd3;
  localparam logic [2:0] StAdd  = 3'd4;
  localparam logic [2:0] StFin  = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [IdxW-1:0]   widx_q, widx_d;
  logic [StepW-1:0]  step_q, step_d;
  logic              ends_q, ends_d;
  logic              mark_q, mark_d;
  logic              wrap_q, wrap_d;
  logic              fin_q, fin_d;
  logic [WordW-1:0]  chain_a_q, chain_a_d, chain_b_q, chain_b_d;
  logic [WordW-1:0]  chain_c_q, chain_c_d, chain_d_q, chain_d_d;
  logic [WordW-1:0]  wa_q, wa_d, wb_q, wb_d, wc_q, wc_d, wd_q, wd_d;
  logic [WordW-1:0]  kw_q, kw_d;
  logic [TotalW-1:0] total_q, total_d;
  logic              out_valid_q, out_valid_d;
  md5_out_t          out_q, out_d;

  logic              in_fire;
  logic              out_fire;
  logic [2:0]        cnt;
  logic              in_ends;
  logic [WordW-1:0]  in_word;
  logic              buf_we;
  logic [WordW-1:0]  buf_wdata;
  logic [IdxW-1:0]   buf_ridx;
  logic [WordW-1:0]  buf_rdata;
  logic [StepW-1:0]  next_step;
  logic [StepW-1:0]  rd_step;
  logic [WordW-1:0]  step_b;
  md5_step_ctrl_t    step_ctrl;

  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_fire    = out_valid_q && out_ready_i;

  assign cnt     = (in_data_i.byte_count > 3'd4) ? 3'd4 : in_data_i.byte_count;
  assign in_ends = in_data_i.last || (cnt < 3'd4);

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (3'(j) < cnt) begin
        in_word[8*j +: 8] = in_data_i.message_word[8*j +: 8];
      end else if (3'(j) == cnt) begin
        in_word[8*j +: 8] = PadMark;
      end else begin
        in_word[8*j +: 8] = 8'h00;
      end
    end
  end

  always_comb begin
    if (!mark_q) begin
      buf_wdata = {24'h0, PadMark};
    end else if (!wrap_q && widx_q == 4'd14) begin
      buf_wdata = total_q[WordW-1:0];
    end else if (!wrap_q && widx_q == 4'd15) begin
      buf_wdata = total_q[TotalW-1:WordW];
    end else begin
      buf_wdata = '0;
    end
    if (state_q == StIdle) begin
      buf_wdata = in_word;
    end
  end

  // The buffer read is registered, so the word index runs one step ahead of next_step.
  always_comb begin
    if (state_q == StStep) begin
      rd_step = StepW'(step_q + 6'd2);
    end else if (state_q == StLoad) begin
      rd_step = 6'd1;
    end else begin
      rd_step = '0;
    end
  end

  assign buf_we    = in_fire || (state_q == StPad);
  assign next_step = (state_q == StLoad) ? '0 : StepW'(step_q + 6'd1);
  assign buf_ridx  = md5_g(rd_step);
  assign step_ctrl = '{round: step_q[5:4], shamt: md5_rot(step_q)};

  md5_buffer #(
    .Width (WordW),
    .Depth (BufDepth)
  ) u_buffer (
    .clk_i     (clk_i),
    .we_i      (buf_we),
    .wr_idx_i  (widx_q),
    .wr_data_i (buf_wdata),
    .rd_idx_i  (buf_ridx),
    .rd_data_o (buf_rdata)
  );

  md5_step u_step (
    .a_i    (wa_q),
    .b_i    (wb_q),
    .c_i    (wc_q),
    .d_i    (wd_q),
    .kw_i   (kw_q),
    .ctrl_i (step_ctrl),
    .b_o    (step_b)
  );

  always_comb begin
    state_d     = state_q;
    widx_d      = widx_q;
    step_d      = step_q;
    ends_d      = ends_q;
    mark_d      = mark_q;
    wrap_d      = wrap_q;
    fin_d       = fin_q;
    chain_a_d   = chain_a_q;
    chain_b_d   = chain_b_q;
    chain_c_d   = chain_c_q;
    chain_d_d   = chain_d_q;
    wa_d        = wa_q;
    wb_d        = wb_q;
    wc_d        = wc_q;
    wd_d        = wd_q;
    kw_d        = md5_k(next_step) + buf_rdata;
    total_d     = total_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_fire;

    case (state_q)
      StIdle: begin
        if (in_fire) begin
          total_d = total_q + {58'd0, cnt, 3'd0};
          ends_d  = in_ends;
          mark_d  = (cnt < 3'd4);
          wrap_d  = (cnt < 3'd4) && (widx_q >= 4'd14);
          fin_d   = 1'b0;
          widx_d  = IdxW'(widx_q + 4'd1);
          if (widx_q == 4'd15) begin
            state_d = StLoad;
          end else if (in_ends) begin
            state_d = StPad;
          end
        end
      end
      StPad: begin
        widx_d = IdxW'(widx_q + 4'd1);
        if (!mark_q) begin
          mark_d = 1'b1;
          wrap_d = (widx_q >= 4'd14);
        end
        if (widx_q == 4'd15) begin
          fin_d   = mark_q && !wrap_q;
          state_d = StLoad;
        end
      end
      StLoad: begin
        wa_d    = chain_a_q;
        wb_d    = chain_b_q;
        wc_d    = chain_c_q;
        wd_d    = chain_d_q;
        step_d  = '0;
        state_d = StStep;
      end
      StStep: begin
        wa_d   = wd_q;
        wb_d   = step_b;
        wc_d   = wb_q;
        wd_d   = wc_q;
        step_d = next_step;
        if (step_q == 6'd63) begin
          state_d = StAdd;
        end
      end
      StAdd: begin
        chain_a_d = chain_a_q + wa_q;
        chain_b_d = chain_b_q + wb_q;
        chain_c_d = chain_c_q + wc_q;
        chain_d_d = chain_d_q + wd_q;
        widx_d    = '0;
        wrap_d    = 1'b0;
        if (fin_q) begin
          state_d = StFin;
        end else if (ends_q) begin
          state_d = StPad;
        end else begin
          state_d = StIdle;
        end
      end
      StFin: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.digest_hi = {md5_bswap(chain_a_q), md5_bswap(chain_b_q)};
          out_d.digest_lo = {md5_bswap(chain_c_q), md5_bswap(chain_d_q)};
          out_valid_d     = 1'b1;
          chain_a_d       = InitA;
          chain_b_d       = InitB;
          chain_c_d       = InitC;
          chain_d_d       = InitD;
          total_d         = '0;
          widx_d          = '0;
          ends_d          = 1'b0;
          mark_d          = 1'b0;
          wrap_d          = 1'b0;
          fin_d           = 1'b0;
          state_d         = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      widx_q      <= '0;
      step_q      <= '0;
      ends_q      <= 1'b0;
      mark_q      <= 1'b0;
      wrap_q      <= 1'b0;
      fin_q       <= 1'b0;
      chain_a_q   <= InitA;
      chain_b_q   <= InitB;
      chain_c_q   <= InitC;
      chain_d_q   <= InitD;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      widx_q      <= widx_d;
      step_q      <= step_d;
      ends_q      <= ends_d;
      mark_q      <= mark_d;
      wrap_q      <= wrap_d;
      fin_q       <= fin_d;
      chain_a_q   <= chain_a_d;
      chain_b_q   <= chain_b_d;
      chain_c_q   <= chain_c_d;
      chain_d_q   <= chain_d_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wa_q  <= wa_d;
    wb_q  <= wb_d;
    wc_q  <= wc_d;
    wd_q  <= wd_d;
    kw_q  <= kw_d;
    out_q <= out_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StStep && step_q == 6'd63) |=> (state_q == StAdd))
    else $error("compression did not end after the last step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPad && wrap_q) |-> !fin_q)
    else $error("length written into a block without room for it");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFin && (!out_valid_q || out_ready_i))
      |=> (out_valid_o && chain_a_q == InitA && total_q == '0))
    else $error("digest not issued or state not restarted");

endmodule
`default_nettype wire

### tb/sv/md5_hash_engine_tb.sv
// Self-checking testbench for md5_hash_engine with a built-in MD5 digest predictor.
module md5_hash_engine_tb;
  import md5_pkg::*;

  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned TailCycles = 300;

  typedef struct packed {
    md5_in_t  item;
    logic     known;
    md5_out_t digest;
  } dir_row_t;

  typedef struct {
    bit       known;
    md5_out_t digest;
  } typed_digest_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  md5_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  md5_out_t out_data;

  int unsigned sender_idle = 31;
  int unsigned recv_idle = 86;
  int unsigned items_sent = 0;
  int unsigned mismatches = 0;
  int unsigned digests_seen = 0;
  int unsigned quiet_cycles = 0;

  md5_out_t      pending_digests[$];
  typed_digest_t typed_digests[$];

  logic [31:0] chain_w[4] = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};
  logic [31:0] blk_w[16] = '{default: 32'h0};
  int unsigned blk_fill = 0;
  logic [63:0] msg_bits = '0;

  logic [31:0] step_k[64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
    32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
    32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
    32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
    32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
    32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  int unsigned step_rot[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  dir_row_t directed_rows[15] = '{
    '{'{32'h00000000, 3'd0, 1'b1}, 1'b1, '{64'hd41d8cd98f00b204, 64'he9800998ecf8427e}},
    '{'{32'h00000000, 3'd0, 1'b0}, 1'b1, '{64'hd41d8cd98f00b204, 64'he9800998ecf8427e}},
    '{'{32'hffffff61, 3'd1, 1'b0}, 1'b1, '{64'h0cc175b9c0f1b6a8, 64'h31c399e269772661}},
    '{'{32'h5a636261, 3'd3, 1'b1}, 1'b1, '{64'h900150983cd24fb0, 64'hd6963f7d28e17f72}},
    '{'{32'hffffffff, 3'd4, 1'b0}, 1'b0, '{64'h0, 64'h0}},
    '{'{32'h00000000, 3'd4, 1'b1}, 1'b0, '{64'h0, 64'h0}},
    '{'{32'hffffffff, 3'd7, 1'b0}, 1'b0, '{64'h0, 64'h0}},
    '{'{32'h12345678, 3'd5, 1'b1}, 1'b0, '{64'h0, 64'h0}},
    '{'{32'h80000001, 3'd4, 1'b0}, 1'b0, '{64'h0, 64'h0}},
    '{'{32'hffffffff, 3'd0, 1'b0}, 1'b0, '{64'h0, 64'h0}},
    '{'{32'ha5a55a5a, 3'd2, 1'b1}, 1'b0, '{64'h0, 64'h0}},
    '{'{32'h0f0f0f0f, 3'd6, 1'b1}, 1'b0, '{64'h0, 64'h0}},
    '{'{32'h00000000, 3'd4, 1'b0}, 1'b0, '{64'h0, 64'h0}},
    '{'{32'hffffffff, 3'd3, 1'b0}, 1'b0, '{64'h0, 64'h0}},
    '{'{32'h00ff00ff, 3'd1, 1'b1}, 1'b0, '{64'h0, 64'h0}}
  };

  md5_hash_engine DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned s);
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic logic [31:0] swap_bytes(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  function automatic void fold_block();
    logic [31:0] a, b, c, d, f, t;
    int unsigned i, g, rnd;
    a = chain_w[0];
    b = chain_w[1];
    c = chain_w[2];
    d = chain_w[3];
    for (i = 0; i < 64; i++) begin
      rnd = i / 16;
      case (rnd)
        0: begin
          f = (b & c) | (~b & d);
          g = i;
        end
        1: begin
          f = (d & b) | (~d & c);
          g = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
      endcase
      t = d;
      d = c;
      c = b;
      b = b + rol32(a + f + step_k[i] + blk_w[g], step_rot[rnd * 4 + i % 4]);
      a = t;
    end
    chain_w[0] += a;
    chain_w[1] += b;
    chain_w[2] += c;
    chain_w[3] += d;
  endfunction

  function automatic void absorb_byte(input logic [7:0] v);
    blk_w[blk_fill / 4][8 * (blk_fill % 4) +: 8] = v;
    blk_fill++;
    if (blk_fill == 64) begin
      fold_block();
      blk_fill = 0;
    end
  endfunction

  function automatic bit md5_absorb_word(input md5_in_t it, output md5_out_t digest);
    int unsigned n, k;
    logic [63:0] len;
    n = (it.byte_count > 3'd4) ? 4 : it.byte_count;
    for (k = 0; k < n; k++) begin
      absorb_byte(it.message_word[8 * k +: 8]);
      msg_bits += 64'd8;
    end
    digest = '0;
    if (!it.last && n == 4) return 1'b0;
    len = msg_bits;
    absorb_byte(8'h80);
    while (blk_fill != 56) absorb_byte(8'h00);
    for (k = 0; k < 8; k++) absorb_byte(len[8 * k +: 8]);
    digest.digest_hi = {swap_bytes(chain_w[0]), swap_bytes(chain_w[1])};
    digest.digest_lo = {swap_bytes(chain_w[2]), swap_bytes(chain_w[3])};
    chain_w = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};
    blk_fill = 0;
    msg_bits = '0;
    return 1'b1;
  endfunction

  task automatic note_mismatch(input string field, input logic [63:0] got,
                               input logic [63:0] want);
    $display("digest %0d: %s got %h, want %h", digests_seen, field, got, want);
    mismatches++;
  endtask

  task automatic send_item(input md5_in_t it, input bit known, input md5_out_t digest);
    typed_digest_t td;
    while ($urandom_range(99) < sender_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    td.known = known;
    td.digest = digest;
    typed_digests.push_back(td);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!(in_valid && in_ready));
    items_sent++;
  endtask

  task automatic send_message();
    md5_in_t it;
    int unsigned sel, nwords, k;
    sel = $urandom_range(99);
    if (sel < 60) nwords = $urandom_range(8);
    else if (sel < 85) nwords = $urandom_range(18, 12);
    else nwords = $urandom_range(40, 19);
    for (k = 0; k < nwords; k++) begin
      it.message_word = $urandom;
      it.byte_count = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'd4;
      it.last = 1'b0;
      send_item(it, 1'b0, '0);
    end
    it.message_word = $urandom;
    it.byte_count = 3'($urandom_range(7));
    it.last = (it.byte_count >= 3'd4) ? 1'b1 : 1'($urandom_range(1));
    send_item(it, 1'b0, '0);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_digests.size() != 0) @(posedge clk);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    typed_digest_t td;
    md5_out_t predicted, want;
    if (rst_n) begin
      quiet_cycles++;
      if (in_valid && in_ready) begin
        quiet_cycles = 0;
        td = typed_digests.pop_front();
        if (md5_absorb_word(in_data, predicted))
          pending_digests.push_back(td.known ? td.digest : predicted);
      end
      if (out_valid && out_ready) begin
        quiet_cycles = 0;
        if (pending_digests.size() == 0) begin
          note_mismatch("unexpected digest_hi", out_data.digest_hi, 64'h0);
        end else begin
          want = pending_digests.pop_front();
          if (out_data.digest_hi !== want.digest_hi)
            note_mismatch("digest_hi", out_data.digest_hi, want.digest_hi);
          if (out_data.digest_lo !== want.digest_lo)
            note_mismatch("digest_lo", out_data.digest_lo, want.digest_lo);
        end
        digests_seen++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].known, directed_rows[i].digest);
    hold_until_drained();
    while (items_sent < 550) send_message();
    hold_until_drained();
    sender_idle = 86;
    recv_idle = 31;
    while (items_sent < 1100) send_message();
    hold_until_drained();
    sender_idle = 0;
    recv_idle = 0;
    while (items_sent < 1650) send_message();
    hold_until_drained();
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0 && pending_digests.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
